/* hdl/nnsrch_pkg.sv */
// ----------------------------------------------------------------------------
// nnsrch_pkg
// Shared constants, action codes, microcode word and control store for the
// 2D nearest neighbor search block.
// ----------------------------------------------------------------------------
package nnsrch_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;

  // Action codes on the input channel
  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Microprogram step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SCAN      = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ROOT_INIT = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ROOT      = 3'd4;
  localparam logic [STEP_W-1:0] STEP_OUT       = 3'd5;

  // Jump conditions: jump to target when true, else hold the step
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_QUERY,
    COND_SCAN_END,
    COND_PIPE_EMPTY,
    COND_ROOT_END,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic              in_ready;
    logic              scan_issue;
    logic              root_init;
    logic              root_step;
    logic              out_load;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t uc;
    uc = '{in_ready: 1'b0, scan_issue: 1'b0, root_init: 1'b0, root_step: 1'b0,
           out_load: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    case (addr)
      STEP_IDLE: begin
        uc.in_ready = 1'b1;
        uc.cond     = COND_QUERY;
        uc.target   = STEP_SCAN;
      end
      STEP_SCAN: begin
        uc.scan_issue = 1'b1;
        uc.cond       = COND_SCAN_END;
        uc.target     = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        uc.cond   = COND_PIPE_EMPTY;
        uc.target = STEP_ROOT_INIT;
      end
      STEP_ROOT_INIT: begin
        uc.root_init = 1'b1;
        uc.cond      = COND_ALWAYS;
        uc.target    = STEP_ROOT;
      end
      STEP_ROOT: begin
        uc.root_step = 1'b1;
        uc.cond      = COND_ROOT_END;
        uc.target    = STEP_OUT;
      end
      STEP_OUT: begin
        uc.out_load = 1'b1;
        uc.cond     = COND_OUT_FREE;
        uc.target   = STEP_IDLE;
      end
      default: begin
        uc.cond   = COND_ALWAYS;
        uc.target = STEP_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

/* hdl/nearest_neighbor_2d_search.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_2d_search
// Point store with brute force nearest neighbor query, microcoded control.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | to block  | in_valid_i/in_stall_o | action_i, point_x_i, point_y_i
//  out     | from block| out_valid_o/out_stall_i | found_o, nearest_x_o, nearest_y_o,
//          |           |                     | distance_o
//
//  Clear and load are taken back to back.
//  A query runs the scan loop, one store read per cycle, a drain of the
//  3 stage pipeline, a root setup step, one square root bit pair per cycle,
//  then the result write. The input stalls until the result is written.
//  Reset clears the count and control state; the store needs no clearing pass.
//  A result waiting on out_stall_i does not block clears, loads or the next
//  query scan; only the final result write waits for the output register.
// ----------------------------------------------------------------------------
module nearest_neighbor_2d_search #(
  parameter int MAX_POINTS = nnsrch_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = nnsrch_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nnsrch_pkg::ACT_W-1:0]  action_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic signed [COORD_BITS-1:0]  nearest_x_o,
  output logic signed [COORD_BITS-1:0]  nearest_y_o,
  output logic [COORD_BITS+1:0]         distance_o
);
  import nnsrch_pkg::*;

  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int DIST_W     = COORD_BITS + 2;
  localparam int SQ_W       = 2 * COORD_BITS + 1;      // dx^2 + dy^2 never overflows
  localparam int ROOT_STEPS = (SQ_W + 1) / 2;
  localparam int RCW        = $clog2(ROOT_STEPS + 1);

  // --------------------------------------------------------------------------
  // Sequencer: step counter plus control store
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0] upc_q, upc_d;
  ucode_t            uc;
  logic              cond_true;

  logic in_acc, out_free, query_start;

  // point store
  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic [CW-1:0]         count_q, count_d;
  logic                  store_wr;

  // query and scan
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [CW-1:0]                idx_q, idx_d;
  logic                         issue, scan_end;

  // scan pipeline: read, difference, square, compare
  logic                  v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic [COORD_BITS-1:0] x2_q, y2_q, x3_q, y3_q;
  logic [COORD_BITS-1:0] dx_q, dy_q;
  logic [2*COORD_BITS-1:0] sx_q, sy_q;
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SQ_W-1:0]       dsum;
  logic                  take;
  logic                  pipe_empty;

  logic                  have_q, have_d;
  logic [SQ_W-1:0]       best_q;
  logic [COORD_BITS-1:0] bx_q, by_q;

  // square root unit
  logic [SQ_W-1:0] rn_q, rres_q, rbit_q;
  logic [SQ_W:0]   rtrial;
  logic            rfit;
  logic [RCW-1:0]  rcnt_q;
  logic            root_end;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [COORD_BITS-1:0] ox_q, oy_q;
  logic [DIST_W-1:0]     odist_q;
  logic                  out_fire;

  assign uc = ucode_rom(upc_q);

  assign in_stall_o  = ~uc.in_ready;
  assign in_acc      = in_valid_i & uc.in_ready;
  assign query_start = in_acc & (action_i == ACT_QUERY);
  assign out_free    = ~out_valid_q | ~out_stall_i;

  assign issue      = uc.scan_issue & (idx_q < count_q);
  assign scan_end   = (idx_q + CW'(1)) >= count_q;
  assign pipe_empty = ~v1_q & ~v2_q & ~v3_q;
  assign root_end   = (rcnt_q == RCW'(1));

  always_comb begin
    case (uc.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_QUERY:      cond_true = query_start;
      COND_SCAN_END:   cond_true = scan_end;
      COND_PIPE_EMPTY: cond_true = pipe_empty;
      COND_ROOT_END:   cond_true = root_end;
      COND_OUT_FREE:   cond_true = out_free;
      default:         cond_true = 1'b1;
    endcase
    upc_d = cond_true ? uc.target : upc_q;
  end

  // --------------------------------------------------------------------------
  // Store management: clear resets the count, loads past capacity drop
  // --------------------------------------------------------------------------
  assign store_wr = in_acc & (action_i == ACT_LOAD) & (count_q < CW'(MAX_POINTS));

  always_comb begin
    count_d = count_q;
    if (in_acc && action_i == ACT_CLEAR) begin
      count_d = '0;
    end else if (store_wr) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      mem_x[count_q[AW-1:0]] <= point_x_i;
      mem_y[count_q[AW-1:0]] <= point_y_i;
    end
    rd_x_q <= mem_x[idx_q[AW-1:0]];
    rd_y_q <= mem_y[idx_q[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Scan pipeline
  // --------------------------------------------------------------------------
  always_comb begin
    idx_d = idx_q;
    if (query_start) begin
      idx_d = '0;
    end else if (uc.scan_issue) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // stage 2: absolute differences (range fits COORD_BITS unsigned)
  assign diff_x = $signed({qx_q[COORD_BITS-1], qx_q})
                - $signed({rd_x_q[COORD_BITS-1], rd_x_q});
  assign diff_y = $signed({qy_q[COORD_BITS-1], qy_q})
                - $signed({rd_y_q[COORD_BITS-1], rd_y_q});
  assign adx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign ady = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

  // stage 4: sum, skip points equal to the query, first strict minimum wins
  assign dsum = {1'b0, sx_q} + {1'b0, sy_q};
  assign take = v3_q & (dsum != '0) & (~have_q | (dsum < best_q));

  always_comb begin
    have_d = have_q;
    if (query_start) begin
      have_d = 1'b0;
    end else if (take) begin
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_start) begin
      qx_q <= point_x_i;
      qy_q <= point_y_i;
    end
    dx_q <= adx;
    dy_q <= ady;
    x2_q <= rd_x_q;
    y2_q <= rd_y_q;
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    x3_q <= x2_q;
    y3_q <= y2_q;
    if (take) begin
      best_q <= dsum;
      bx_q   <= x3_q;
      by_q   <= y3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per step, restoring method
  // --------------------------------------------------------------------------
  assign rtrial = {1'b0, rres_q} + {1'b0, rbit_q};
  assign rfit   = {1'b0, rn_q} >= rtrial;

  always_ff @(posedge clk_i) begin
    if (uc.root_init) begin
      rn_q   <= have_q ? best_q : '0;
      rres_q <= '0;
      rbit_q <= {1'b1, {(SQ_W-1){1'b0}}};
    end else if (uc.root_step) begin
      if (rfit) begin
        rn_q   <= rn_q - rtrial[SQ_W-1:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign out_fire    = uc.out_load & out_free;
  assign out_valid_d = out_fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      found_q <= have_q;
      ox_q    <= have_q ? bx_q : '0;
      oy_q    <= have_q ? by_q : '0;
      odist_q <= rres_q[DIST_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign nearest_x_o = ox_q;
  assign nearest_y_o = oy_q;
  assign distance_o  = odist_q;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= STEP_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      have_q      <= 1'b0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      if (uc.root_init) begin
        rcnt_q <= RCW'(ROOT_STEPS);
      end else if (uc.root_step) begin
        rcnt_q <= rcnt_q - RCW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (upc_q == STEP_SCAN || upc_q == STEP_DRAIN))
    else $error("scan pipeline busy outside scan");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == STEP_SCAN) |-> (idx_q <= count_q))
    else $error("scan index beyond point count");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (distance_o == '0 && nearest_x_o == '0
                                   && nearest_y_o == '0))
    else $error("not found result carries nonzero fields");

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == STEP_OUT && out_free) |=> (out_valid_o && upc_q == STEP_IDLE))
    else $error("result write lost");

endmodule
